// ===== sv/ptf_pkg.sv =====
// paging frame tracker: shared types, field widths, codes and helpers
// no dependencies; imported by the top level, the checker and the testbench

package ptf_pkg;

  // field widths
  localparam int SFN_W   = 10;
  localparam int CYC_W   = 11;
  localparam int UEID_W  = 10;
  localparam int RECID_W = 16;
  localparam int MODE_W  = 2;

  // frame counter wraps at this value
  localparam int SFN_MODULO    = 1024;
  // a resync after first lock only lands on multiples of this
  localparam int RESYNC_PERIOD = 80;

  // defaults
  localparam int                FRAME_SLOTS_DEF = 8;
  localparam logic [UEID_W-1:0] UE_ID_RST       = UEID_W'(102);

  // restoring divider steps, one quotient bit per step
  localparam int DIV_STEPS = CYC_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // shared add/sub unit: 12-bit operands plus a borrow bit
  localparam int ALU_W   = CYC_W + 2;
  // running paging frame, below 2048 + T at most
  localparam int FRAME_W = CYC_W + 1;

  // beat layouts
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam int IN_SFN_LSB   = 0;
  localparam int IN_DRX_LSB   = IN_SFN_LSB + SFN_W;
  localparam int IN_N_LSB     = IN_DRX_LSB + CYC_W;
  localparam int IN_RECID_LSB = IN_N_LSB + CYC_W;

  localparam int OUT_SFN_LSB  = 0;
  localparam int OUT_SYNC_BIT = SFN_W;
  localparam int OUT_PF_BIT   = SFN_W + 1;
  localparam int OUT_PAGE_BIT = SFN_W + 2;
  localparam int OUT_USED_W   = SFN_W + 3;

  // item kinds carried in tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_MIB  = 2'd1,
    MODE_SIB1 = 2'd2,
    MODE_REC  = 2'd3
  } ptf_mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_Q,
    ST_DIV_R,
    ST_MUL,
    ST_FILL,
    ST_SCAN,
    ST_DONE
  } ptf_state_t;

  // true when v is a multiple of the resync period (independent compares)
  function automatic logic is_resync_frame(input logic [SFN_W-1:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= (SFN_MODULO - 1) / RESYNC_PERIOD; k++) begin
      hit = hit | (v == SFN_W'(k * RESYNC_PERIOD));
    end
    return hit;
  endfunction

endpackage

// ===== sv/paging_frame_tracker_unit.sv =====
// paging frame tracker top level: frame counter, sync flag, paging setup sequencer
// depends on ptf_pkg and ptf_ram (paging frame store)
// tick, MIB and record items go from idle through the frame store scan to done; a
//   SIB1 item with nonzero cycle and N first runs two divisions of 11 divider steps,
//   one multiply and the fill of up to FRAME_SLOTS slots. a beat is taken only in
//   idle, after the one-slot-per-cycle scan and hand-off. reset (rst_n, synchronous)
//   clears counter, sync flag and slot valid bits; the identity returns to 102

module paging_frame_tracker_unit
  import ptf_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config: ue_identity
  input  logic                  cfg_we,
  input  logic [UEID_W-1:0]     cfg_wdata,
  // input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // frame_no[9:0], paging_cycle[20:10], n_value[31:21], paging_ue_id[47:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     in_tuser,
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // current_sfn[9:0], synced[10], in_paging_frame[11], paged[12], zero[15:13]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W = $clog2(FRAME_SLOTS + 1);

  // input fields
  logic [SFN_W-1:0]   in_sfn;
  logic [CYC_W-1:0]   in_drx;
  logic [CYC_W-1:0]   in_n;
  logic [RECID_W-1:0] in_recid;
  ptf_mode_t          in_mode;

  assign in_sfn   = in_tdata[IN_SFN_LSB +: SFN_W];
  assign in_drx   = in_tdata[IN_DRX_LSB +: CYC_W];
  assign in_n     = in_tdata[IN_N_LSB +: CYC_W];
  assign in_recid = in_tdata[IN_RECID_LSB +: RECID_W];
  assign in_mode  = ptf_mode_t'(in_tuser);

  // registers
  ptf_state_t              state_r, state_nxt;
  logic [UEID_W-1:0]       ue_id_r;
  logic [SFN_W-1:0]        sfn_r, sfn_nxt;
  logic                    sync_r, sync_nxt;
  logic [FRAME_SLOTS-1:0]  valid_r, valid_nxt;
  ptf_mode_t               mode_r, mode_nxt;
  logic [CYC_W-1:0]        t_r, t_nxt;
  logic [CYC_W-1:0]        n_r, n_nxt;
  logic [RECID_W-1:0]      recid_r, recid_nxt;
  logic [CYC_W-1:0]        quo_r, quo_nxt;
  logic [CYC_W-1:0]        rem_r, rem_nxt;
  logic [CYC_W-1:0]        q_r, q_nxt;
  logic [DCNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic [FRAME_W-1:0]      frame_r, frame_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    vq_r, vq_nxt;
  logic                    hit_r, hit_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  // shared add/sub unit
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub;

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

  // frame store
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [SFN_W-1:0] ram_wdata, ram_rdata;

  ptf_ram #(
    .WIDTH (SFN_W),
    .DEPTH (FRAME_SLOTS),
    .AW    (IDX_W)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divider step helpers
  logic [CYC_W:0]   div_shift;
  logic             div_fit;
  logic [SFN_W-1:0] slot_val;
  logic             slot_match;

  assign div_shift  = {rem_r, quo_r[CYC_W-1]};
  assign div_fit    = ~alu_res[ALU_W-1];
  assign slot_val   = vq_r ? ram_rdata : '0;
  assign slot_match = rd_pend_r && (slot_val == sfn_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ue_id_r <= UE_ID_RST;
    end else if (cfg_we) begin
      ue_id_r <= cfg_wdata;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sfn_r       <= '0;
      sync_r      <= 1'b0;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sfn_r       <= sfn_nxt;
      sync_r      <= sync_nxt;
      valid_r     <= valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    t_r        <= t_nxt;
    n_r        <= n_nxt;
    recid_r    <= recid_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    dcnt_r     <= dcnt_nxt;
    frame_r    <= frame_nxt;
    cnt_r      <= cnt_nxt;
    vq_r       <= vq_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    sfn_nxt       = sfn_r;
    sync_nxt      = sync_r;
    valid_nxt     = valid_r;
    mode_nxt      = mode_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    recid_nxt     = recid_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    frame_nxt     = frame_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    vq_nxt        = vq_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[IDX_W-1:0];
    ram_wdata     = frame_r[SFN_W-1:0];
    ram_raddr     = cnt_r[IDX_W-1:0];

    // output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_mode;
          t_nxt     = in_drx;
          n_nxt     = in_n;
          recid_nxt = in_recid;
          quo_nxt   = in_drx;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_SCAN;
          case (in_mode)
            MODE_TICK: begin
              sfn_nxt = sfn_r + SFN_W'(1);
            end
            MODE_MIB: begin
              if (!sync_r) begin
                sfn_nxt  = in_sfn;
                sync_nxt = 1'b1;
              end else if (is_resync_frame(in_sfn)) begin
                sfn_nxt = in_sfn;
              end
            end
            MODE_SIB1: begin
              if ((in_n != '0) && (in_drx != '0)) begin
                state_nxt = ST_DIV_Q;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // quotient T / N, one bit per cycle
      ST_DIV_Q: begin
        alu_a   = ALU_W'(div_shift);
        alu_b   = ALU_W'(n_r);
        alu_sub = 1'b1;
        rem_nxt = div_fit ? alu_res[CYC_W-1:0] : div_shift[CYC_W-1:0];
        quo_nxt = {quo_r[CYC_W-2:0], div_fit};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          q_nxt     = {quo_r[CYC_W-2:0], div_fit};
          quo_nxt   = CYC_W'(ue_id_r);
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV_R;
        end
      end

      // remainder ue_identity mod N on the same unit
      ST_DIV_R: begin
        alu_a   = ALU_W'(div_shift);
        alu_b   = ALU_W'(n_r);
        alu_sub = 1'b1;
        rem_nxt = div_fit ? alu_res[CYC_W-1:0] : div_shift[CYC_W-1:0];
        quo_nxt = {quo_r[CYC_W-2:0], div_fit};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end

      // first paging frame; the product stays below T so the low bits suffice
      ST_MUL: begin
        frame_nxt = FRAME_W'(q_r * rem_r);
        cnt_nxt   = '0;
        state_nxt = ST_FILL;
      end

      // one slot per cycle while the frame stays below the wrap, up to FRAME_SLOTS slots
      ST_FILL: begin
        if ((cnt_r == CNT_W'(FRAME_SLOTS)) || (frame_r[FRAME_W-1:SFN_W] != '0)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          ram_we                       = 1'b1;
          valid_nxt[cnt_r[IDX_W-1:0]]  = 1'b1;
          alu_a                        = ALU_W'(frame_r);
          alu_b                        = ALU_W'(t_r);
          frame_nxt                    = alu_res[FRAME_W-1:0];
          cnt_nxt                      = cnt_r + CNT_W'(1);
        end
      end

      // read each slot and compare the registered read data with the counter
      ST_SCAN: begin
        if (slot_match) begin
          hit_nxt = 1'b1;
        end
        if (cnt_r != CNT_W'(FRAME_SLOTS)) begin
          rd_pend_nxt = 1'b1;
          vq_nxt      = valid_r[cnt_r[IDX_W-1:0]];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OUT_SFN_LSB +: SFN_W] = sfn_r;
          out_data_nxt[OUT_SYNC_BIT]         = sync_r;
          out_data_nxt[OUT_PF_BIT]           = hit_r;
          out_data_nxt[OUT_PAGE_BIT]         = (mode_r == MODE_REC) && hit_r &&
                                               (recid_r == RECID_W'(ue_id_r));
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ptf_ram.sv =====
// paging frame tracker: generic single-write, single-read ram, registered read
// depends on nothing; used by the top level as the paging frame store

module ptf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ptf_checker.sv =====
// paging frame tracker: port-level checker and its bind to the top level
// depends on ptf_pkg; attaches to paging_frame_tracker_unit

module ptf_checker
  import ptf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // remembers that a delivered beat has shown sync
  logic seen_sync_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_sync_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tdata[OUT_SYNC_BIT]) begin
      seen_sync_r <= 1'b1;
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // one item at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item still in work");

  // sync never drops once shown
  a_sync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_sync_r |-> out_tdata[OUT_SYNC_BIT])
    else $error("sync flag dropped");

  // unused bits of the result stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
    else $error("result padding not zero");

endmodule

bind paging_frame_tracker_unit ptf_checker u_ptf_checker (.*);

// ===== tb/tb_top.sv =====
// testbench for the paging frame tracker: directed table, then random phases
// depends on ptf_pkg and paging_frame_tracker_unit; self-checking, no files
`timescale 1ns / 1ps

module tb_top;
  import ptf_pkg::*;

  localparam int SLOTS       = FRAME_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BEATS = 180;
  localparam int NUM_PHASES  = 7;
  localparam int DRAIN_CYC   = 64;
  localparam int MAX_PRINTS  = 40;

  // one input beat, split into its fields
  typedef struct packed {
    ptf_mode_t           mode;
    logic [SFN_W-1:0]    sfn;
    logic [CYC_W-1:0]    drx;
    logic [CYC_W-1:0]    nval;
    logic [RECID_W-1:0]  recid;
  } paging_item_t;

  // result beat, laid out as out_tdata (msb first)
  typedef struct packed {
    logic [2:0]          pad;
    logic                paged;
    logic                in_pf;
    logic                synced;
    logic [SFN_W-1:0]    sfn;
  } frame_status_t;

  // directed row: beat, plus a typed result where it is obvious
  typedef struct packed {
    paging_item_t        item;
    logic                fixed;
    frame_status_t       want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // want fields: pad, paged, in_pf, synced, sfn
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    // frame 0 is a paging frame straight after reset
    '{'{MODE_REC,  10'd0,    11'd0,    11'd0,    16'd102},   1'b1, '{3'd0, 1'b1, 1'b1, 1'b0, 10'd0}},
    '{'{MODE_REC,  10'd0,    11'd0,    11'd0,    16'hFFFF},  1'b1, '{3'd0, 1'b0, 1'b1, 1'b0, 10'd0}},
    '{'{MODE_TICK, 10'd0,    11'd0,    11'd0,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b0, 1'b0, 10'd1}},
    // first sync loads any value
    '{'{MODE_MIB,  10'd1023, 11'd0,    11'd0,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b0, 1'b1, 10'd1023}},
    // counter wraps
    '{'{MODE_TICK, 10'd0,    11'd0,    11'd0,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b1, 1'b1, 10'd0}},
    // resync off the 80 grid is ignored, on the grid it loads
    '{'{MODE_MIB,  10'd517,  11'd0,    11'd0,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b1, 1'b1, 10'd0}},
    '{'{MODE_MIB,  10'd960,  11'd0,    11'd0,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b0, 1'b1, 10'd960}},
    // cycle zero, N zero, offset past the frame range: table untouched
    '{'{MODE_SIB1, 10'd0,    11'd0,    11'd4,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b0, 1'b1, 10'd960}},
    '{'{MODE_SIB1, 10'd0,    11'd32,   11'd0,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b0, 1'b1, 10'd960}},
    '{'{MODE_SIB1, 10'd0,    11'd2047, 11'd103,  16'd0},     1'b1, '{3'd0, 1'b0, 1'b0, 1'b1, 10'd960}},
    '{'{MODE_MIB,  10'd0,    11'd0,    11'd0,    16'd0},     1'b1, '{3'd0, 1'b0, 1'b1, 1'b1, 10'd0}},
    // full table, then hits and misses against it
    '{'{MODE_SIB1, 10'd0,    11'd32,   11'd4,    16'd0},     1'b0, '0},
    '{'{MODE_REC,  10'd0,    11'd0,    11'd0,    16'd102},   1'b0, '0},
    '{'{MODE_MIB,  10'd160,  11'd0,    11'd0,    16'd0},     1'b0, '0},
    '{'{MODE_MIB,  10'd80,   11'd0,    11'd0,    16'd0},     1'b0, '0},
    '{'{MODE_REC,  10'd0,    11'd0,    11'd0,    16'd102},   1'b0, '0},
    '{'{MODE_REC,  10'd0,    11'd0,    11'd0,    16'd101},   1'b0, '0},
    // one frame only: the other slots keep old entries
    '{'{MODE_SIB1, 10'd0,    11'd1024, 11'd1,    16'd0},     1'b0, '0},
    '{'{MODE_TICK, 10'd0,    11'd0,    11'd0,    16'd0},     1'b0, '0},
    // N above the cycle gives a zero offset step
    '{'{MODE_SIB1, 10'd0,    11'd4,    11'd1000, 16'd0},     1'b0, '0},
    // widest fields, noise in the unused ones
    '{'{MODE_SIB1, 10'd1023, 11'd2047, 11'd2047, 16'hFFFF},  1'b0, '0},
    // more frames than slots
    '{'{MODE_SIB1, 10'd0,    11'd8,    11'd8,    16'd0},     1'b0, '0},
    '{'{MODE_SIB1, 10'd0,    11'd1,    11'd1024, 16'd0},     1'b0, '0},
    '{'{MODE_REC,  10'd0,    11'd0,    11'd0,    16'd102},   1'b0, '0},
    '{'{MODE_TICK, 10'd1023, 11'd2047, 11'd2047, 16'hFFFF},  1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [UEID_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state
  logic [SFN_W-1:0]      sfn_now;
  logic                  synced_now;
  logic [SFN_W-1:0]      pf_tab [SLOTS];
  logic [UEID_W-1:0]     ue_now;

  frame_status_t         status_q [$];
  int                    err_cnt;
  int                    n_results;
  int                    n_pf_hits;
  int                    n_pages;
  int                    n_settings;
  int                    idle_pct;
  int                    cycles;

  paging_frame_tracker_unit #(.FRAME_SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predicts the status after one beat and advances the predictor state
  function automatic frame_status_t track_frame(paging_item_t it);
    frame_status_t r;
    int first;
    int frame;
    r = '0;
    case (it.mode)
      MODE_TICK: sfn_now = sfn_now + 1'b1;
      MODE_MIB: begin
        if (!synced_now) begin
          sfn_now    = it.sfn;
          synced_now = 1'b1;
        end else if (int'(it.sfn) % RESYNC_PERIOD == 0) begin
          sfn_now = it.sfn;
        end
      end
      MODE_SIB1: begin
        if (it.nval != '0 && it.drx != '0) begin
          first = (int'(it.drx) / int'(it.nval)) * (int'(ue_now) % int'(it.nval));
          for (int k = 0; k < SLOTS; k++) begin
            frame = first + k * int'(it.drx);
            if (frame >= SFN_MODULO) break;
            pf_tab[k] = frame[SFN_W-1:0];
          end
        end
      end
      default: ;
    endcase
    foreach (pf_tab[k]) if (pf_tab[k] == sfn_now) r.in_pf = 1'b1;
    r.paged  = (it.mode == MODE_REC) && r.in_pf && (it.recid == RECID_W'(ue_now));
    r.sfn    = sfn_now;
    r.synced = synced_now;
    return r;
  endfunction

  // random beat, biased towards sequences that reach paging hits
  function automatic paging_item_t random_item();
    paging_item_t it;
    int pick;
    pick     = $urandom_range(0, 99);
    it.sfn   = SFN_W'($urandom_range(0, 1023));
    it.drx   = CYC_W'($urandom_range(0, 2047));
    it.nval  = CYC_W'($urandom_range(0, 2047));
    it.recid = RECID_W'($urandom_range(0, 65535));
    if (pick < 40) begin
      it.mode = MODE_TICK;
    end else if (pick < 70) begin
      it.mode = MODE_REC;
      if ($urandom_range(0, 1) == 0) it.recid = RECID_W'(ue_now);
    end else if (pick < 82) begin
      it.mode = MODE_MIB;
      if ($urandom_range(0, 1) == 0) it.sfn = SFN_W'(RESYNC_PERIOD * $urandom_range(0, 12));
    end else begin
      it.mode = MODE_SIB1;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        it.drx  = CYC_W'(1 << $urandom_range(3, 10));
        it.nval = CYC_W'($urandom_range(1, 16));
      end else if (pick == 7) begin
        it.nval = '0;
      end else if (pick == 8) begin
        it.drx = '0;
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // drive one beat and wait for the handshake, then predict it
  task automatic send_beat(paging_item_t it, logic fixed, frame_status_t want);
    frame_status_t pred;
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = it.mode;
    in_tdata  = {it.recid, it.nval, it.drx, it.sfn};
    do @(posedge clk); while (!in_tready);
    pred = track_frame(it);
    status_q.insert(status_q.size(), fixed ? want : pred);
  endtask

  // lower valid and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  // new ue identity, written only once the block is idle
  task automatic set_identity(logic [UEID_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    ue_now = v;
    n_settings++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    frame_status_t got;
    frame_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = frame_status_t'(out_tdata);
      n_results++;
      if (got.in_pf) n_pf_hits++;
      if (got.paged) n_pages++;
      if (status_q.size() == 0) begin
        report_mismatch("unexpected result beat", int'(out_tdata), -1);
      end else begin
        want = status_q.pop_front();
        if (got.sfn != want.sfn) report_mismatch("current_sfn", got.sfn, want.sfn);
        if (got.synced != want.synced) report_mismatch("synced", got.synced, want.synced);
        if (got.in_pf != want.in_pf)
          report_mismatch("in_paging_frame", got.in_pf, want.in_pf);
        if (got.paged != want.paged) report_mismatch("paged", got.paged, want.paged);
        if (got.pad != want.pad) report_mismatch("tdata padding", got.pad, want.pad);
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n || idle_pct == 0) begin
        out_tready = 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_tready = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall      = $urandom_range(1, 11) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, status_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [UEID_W-1:0] ue_set [NUM_PHASES];
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_TICK;
    err_cnt    = 0;
    n_results  = 0;
    n_pf_hits  = 0;
    n_pages    = 0;
    n_settings = 1;
    idle_pct   = 25;
    cycles     = 0;
    sfn_now    = '0;
    synced_now = 1'b0;
    ue_now     = UE_ID_RST;
    foreach (pf_tab[k]) pf_tab[k] = '0;

    ue_set[0] = '0;
    ue_set[1] = '1;
    ue_set[2] = UEID_W'($urandom_range(0, 1023));
    ue_set[3] = UEID_W'(1);
    ue_set[4] = UEID_W'(512);
    ue_set[5] = UEID_W'($urandom_range(0, 1023));
    ue_set[6] = UEID_W'($urandom_range(0, 1023));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset identity
    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);

    // random phases, one identity each; a calm phase mid-run and at the end
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_identity(ue_set[p]);
      idle_pct = (p == 3 || p == NUM_PHASES - 1) ? 0 : 25;
      for (int i = 0; i < PHASE_BEATS; i++) send_beat(random_item(), 1'b0, '0);
    end

    drain_results();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("checked %0d result beats over %0d identity settings", n_results, n_settings);
    $display("%0d beats in a paging frame, %0d of them paged this ue", n_pf_hits, n_pages);
    if (err_cnt == 0 && status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_cnt, status_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
